### design/prm_pkg.sv
// Shared constants, types and state codes of the pulse period rpm meter.
package prm_pkg;

    // Fraction bits of the rpm fixed point format.
    localparam int FRAC_BITS = 8;

    // Field widths.
    localparam int COUNT_W = 32;
    localparam int TS_W    = 63;
    localparam int RPM_W   = 34;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 8;

    // Dividend: microseconds per minute in Q.FRAC_BITS.
    localparam int NUM_W = 26 + FRAC_BITS;
    localparam logic [NUM_W-1:0] NUM_Q = NUM_W'(64'd60000000 << FRAC_BITS);

    // Multiplier operand widths: a 17 bit weight or pulse count against a speed or a period.
    localparam int MA_W   = CFG_W + 1;
    localparam int MB_W   = (NUM_W > RPM_W) ? NUM_W : RPM_W;
    localparam int PROD_W = MA_W + MB_W;

    // Divisor, remainder and filter accumulator widths.
    localparam int DEN_W = CFG_W + NUM_W;
    localparam int REM_W = DEN_W + 1;
    localparam int ACC_W = RPM_W + MA_W;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};
    localparam logic [MA_W-1:0]  ALPHA_ONE = MA_W'(65536);

    // Register reset values.
    localparam logic [CFG_W-1:0] PPR_RESET   = CFG_W'(20);
    localparam logic [CFG_W-1:0] ALPHA_RESET = CFG_W'(13107);

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_PULSES_PER_REV = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FILTER_ALPHA   = IDX_W'(1);

    // Item codes.
    localparam logic ACT_POLL    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DEN,
        ST_DIV,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_EMIT
    } prm_state_t;

endpackage

### design/prm_item_if.sv
// Input item channel: poll or speed request.
interface prm_item_if import prm_pkg::*;;
    logic               valid;
    logic               ready;
    logic               action;
    logic [COUNT_W-1:0] pulse_count;
    logic [TS_W-1:0]    timestamp_us;

    modport source (output valid, action, pulse_count, timestamp_us, input ready);
    modport sink   (input valid, action, pulse_count, timestamp_us, output ready);
endinterface

### design/prm_result_if.sv
// Result channel: filtered speed and period flag.
interface prm_result_if import prm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [RPM_W-1:0] rpm_q8;
    logic             has_period;

    modport source (output valid, rpm_q8, has_period, input ready);
    modport sink   (input valid, rpm_q8, has_period, output ready);
endinterface

### design/prm_cfg_if.sv
// Configuration write channel: register index and write data.
interface prm_cfg_if import prm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/pulse_period_rpm_meter.sv
// Period tachometer: pulse period capture, bit-serial divide and exponential average.
// A poll gives no result; the block is ready again the next cycle.
// A request with no positive period goes through the emit state to the output register.
// A positive-period request runs the divider steps, 3 multiplier steps and one emit step;
// a zero pulses-per-rev or a period above NUM_Q skips the divide and the first multiply.
// One item at a time: the input is ready only in the idle state; a stalled result holds emit.
// Reset (rst_n low, asynchronous) clears the history and average and restores the registers.
module pulse_period_rpm_meter import prm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    prm_item_if.sink           item,
    prm_result_if.source       result,
    prm_cfg_if.sink            cfg
);

    prm_state_t         state_reg, state_next;

    logic [CFG_W-1:0]   ppr_reg, ppr_next;
    logic [CFG_W-1:0]   alpha_reg, alpha_next;
    logic [COUNT_W-1:0] prev_count_reg, prev_count_next;
    logic [TS_W-1:0]    prev_time_reg, prev_time_next;
    logic [63:0]        period_reg, period_next;
    logic               no_change_reg, no_change_next;
    logic [RPM_W-1:0]   avg_reg, avg_next;

    logic               out_valid_reg, out_valid_next;
    logic [RPM_W-1:0]   out_rpm_reg, out_rpm_next;
    logic               out_has_reg, out_has_next;

    logic               has_reg, has_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RPM_W-1:0]   raw_reg, raw_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    logic [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [PROD_W-1:0]  prod;
    logic [ACC_W-1:0]   acc_sum;
    logic [REM_W-1:0]   rem_shift;
    logic               rem_ge;
    logic [MB_W-1:0]    quo_ext;
    logic               positive;
    logic               item_xfer;

    assign item.ready    = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.rpm_q8     = out_rpm_reg;
    assign result.has_period = out_has_reg;

    assign item_xfer = item.valid && item.ready;
    assign positive  = !no_change_reg && (period_reg != 64'd0) && !period_reg[63];

    // Shared multiplier: operands chosen by the sequencer step
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_NEW:
            begin
                mul_a = MA_W'(alpha_reg);
                mul_b = MB_W'(raw_reg);
            end
            ST_MUL_OLD:
            begin
                mul_a = ALPHA_ONE - MA_W'(alpha_reg);
                mul_b = MB_W'(avg_reg);
            end
            default:
            begin
                mul_a = MA_W'(ppr_reg);
                mul_b = period_reg[MB_W-1:0];
            end
        endcase
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_sum = acc_reg + prod[ACC_W-1:0];

    // Divider step: bring down one dividend bit, subtract when it fits
    assign rem_shift = {rem_reg[DEN_W-1:0], NUM_Q[cnt_reg]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});
    assign quo_ext   = MB_W'({quo_reg[NUM_W-2:0], rem_ge});

    // Sequencer, history update and configuration writes
    always_comb
    begin
        state_next      = state_reg;
        ppr_next        = ppr_reg;
        alpha_next      = alpha_reg;
        prev_count_next = prev_count_reg;
        prev_time_next  = prev_time_reg;
        period_next     = period_reg;
        no_change_next  = no_change_reg;
        avg_next        = avg_reg;
        out_valid_next  = out_valid_reg;
        out_rpm_next    = out_rpm_reg;
        out_has_next    = out_has_reg;
        has_next        = has_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        raw_next        = raw_reg;
        acc_next        = acc_reg;

        // Drop the result once transferred
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_PULSES_PER_REV)
            begin
                ppr_next = cfg.data;
            end
            else if (cfg.index == REG_FILTER_ALPHA)
            begin
                alpha_next = cfg.data;
            end
        end

        if (rem_ge)
        begin
            rem_next = rem_shift - {1'b0, den_reg};
        end
        else
        begin
            rem_next = rem_shift;
        end
        quo_next = {quo_reg[NUM_W-2:0], rem_ge};

        unique case (state_reg)
            ST_IDLE:
            begin
                rem_next = rem_reg;
                quo_next = quo_reg;
                if (item_xfer)
                begin
                    if (item.action == ACT_POLL)
                    begin
                        // Capture a changed count and the time since the last change
                        if (item.pulse_count != prev_count_reg)
                        begin
                            if (!no_change_reg)
                            begin
                                period_next = {1'b0, item.timestamp_us}
                                            - {1'b0, prev_time_reg};
                            end
                            prev_time_next  = item.timestamp_us;
                            prev_count_next = item.pulse_count;
                            no_change_next  = 1'b0;
                        end
                    end
                    else if (!positive)
                    begin
                        has_next   = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else if (ppr_reg == '0)
                    begin
                        raw_next   = RPM_MAX;
                        state_next = ST_MUL_NEW;
                    end
                    else if (period_reg > 64'(NUM_Q))
                    begin
                        raw_next   = '0;
                        state_next = ST_MUL_NEW;
                    end
                    else
                    begin
                        state_next = ST_MUL_DEN;
                    end
                end
            end
            ST_MUL_DEN:
            begin
                den_next   = prod[DEN_W-1:0];
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    // Saturate the quotient to the speed width
                    if (quo_ext > MB_W'(RPM_MAX))
                    begin
                        raw_next = RPM_MAX;
                    end
                    else
                    begin
                        raw_next = quo_ext[RPM_W-1:0];
                    end
                    state_next = ST_MUL_NEW;
                end
            end
            ST_MUL_NEW:
            begin
                rem_next   = rem_reg;
                quo_next   = quo_reg;
                acc_next   = prod[ACC_W-1:0];
                state_next = ST_MUL_OLD;
            end
            ST_MUL_OLD:
            begin
                rem_next   = rem_reg;
                quo_next   = quo_reg;
                avg_next   = acc_sum[16 +: RPM_W];
                has_next   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                rem_next = rem_reg;
                quo_next = quo_reg;
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_has_next   = has_reg;
                    out_rpm_next   = has_reg ? avg_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ppr_reg        <= PPR_RESET;
            alpha_reg      <= ALPHA_RESET;
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
            period_reg     <= '0;
            no_change_reg  <= 1'b1;
            avg_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ppr_reg        <= ppr_next;
            alpha_reg      <= alpha_next;
            prev_count_reg <= prev_count_next;
            prev_time_reg  <= prev_time_next;
            period_reg     <= period_next;
            no_change_reg  <= no_change_next;
            avg_reg        <= avg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        out_rpm_reg <= out_rpm_next;
        out_has_reg <= out_has_next;
        has_reg     <= has_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        raw_reg     <= raw_next;
        acc_reg     <= acc_next;
    end

    // A result without a period carries zero speed
    a_no_period_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.has_period) |-> (result.rpm_q8 == '0))
        else $error("result without period carries non-zero speed");

    // The remainder stays below the divisor throughout the divide
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, den_reg}))
        else $error("divider remainder not below divisor");

    // The last divide step hands over to the filter multiply
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> (state_reg == ST_MUL_NEW))
        else $error("divider did not finish into filter step");

    // The new average lies between the old average and the raw speed
    a_avg_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_OLD) |->
        ((avg_next <= raw_reg && avg_next >= avg_reg)
         || (avg_next <= avg_reg && avg_next >= raw_reg)))
        else $error("filtered speed outside old average and raw speed");

endmodule

### tb/tb.sv
// Self-checking testbench of the pulse period rpm meter: directed history and register cases,
// then random poll/request traffic under several register settings and idling profiles.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 144;

    // Index with no register behind it; a write there must be dropped.
    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(2);

    // Microseconds per minute in the rpm fixed point format.
    localparam logic [63:0] MINUTE_Q = 64'd60000000 << FRAC_BITS;
    localparam logic [62:0] TS_MAX   = '1;

    typedef struct packed {
        logic [RPM_W-1:0] rpm_q8;
        logic             has_period;
    } speed_result_t;

    logic clk = 1'b0;
    logic rst_n;

    prm_item_if   item_ch ();
    prm_result_if result_ch ();
    prm_cfg_if    cfg_ch ();

    pulse_period_rpm_meter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Predictor copy of the registers and the period history.
    logic [CFG_W-1:0] meter_ppr       = PPR_RESET;
    logic [CFG_W-1:0] meter_alpha     = ALPHA_RESET;
    logic [31:0]      meter_count     = '0;
    logic [63:0]      last_change_us  = '0;
    logic [63:0]      period_us       = '0;
    logic             awaiting_change = 1'b1;
    logic [RPM_W-1:0] rpm_avg         = '0;

    speed_result_t speed_expect_q[$];

    int err_count     = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Generator view of the encoder: running time and count.
    logic [62:0] gen_time_us = '0;
    logic [31:0] gen_count   = '0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Unfiltered speed for a positive period, saturated to the output width.
    function automatic logic [RPM_W-1:0] raw_rpm(input logic [63:0] period);
        logic [63:0] den;
        logic [63:0] quot;
        if (meter_ppr == '0)
            return RPM_MAX;
        if (period > MINUTE_Q)
            return '0;
        den  = 64'(meter_ppr) * period;
        quot = MINUTE_Q / den;
        return (quot > 64'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];
    endfunction

    // Advance the predictor by one accepted item; queue the speed a request produces.
    task automatic predict_item(input logic act, input logic [31:0] count,
                                input logic [62:0] ts);
        logic [63:0]      acc;
        logic [RPM_W-1:0] raw;
        speed_result_t    res;
        if (act == ACT_POLL)
        begin
            if (count != meter_count)
            begin
                if (!awaiting_change)
                    period_us = {1'b0, ts} - last_change_us;
                last_change_us  = {1'b0, ts};
                meter_count     = count;
                awaiting_change = 1'b0;
            end
        end
        else if (awaiting_change || period_us == '0 || period_us[63])
        begin
            res.rpm_q8     = '0;
            res.has_period = 1'b0;
            speed_expect_q.push_back(res);
        end
        else
        begin
            raw = raw_rpm(period_us);
            acc = 64'(meter_alpha) * 64'(raw)
                + (64'd65536 - 64'(meter_alpha)) * 64'(rpm_avg);
            rpm_avg        = acc[16 +: RPM_W];
            res.rpm_q8     = rpm_avg;
            res.has_period = 1'b1;
            speed_expect_q.push_back(res);
        end
    endtask

    // Offer one item after a random idle gap and hold it until the transfer.
    task automatic send_item(input logic act, input logic [31:0] count,
                             input logic [62:0] ts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= act;
        item_ch.pulse_count  <= count;
        item_ch.timestamp_us <= ts;
        do @(posedge clk); while (!item_ch.ready);
        predict_item(act, count, ts);
    endtask

    // Speed request; the poll fields carry junk that must be ignored.
    task automatic send_request();
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        send_item(ACT_REQUEST, $urandom, junk[62:0]);
    endtask

    // Hold the sender until every expected speed has come back.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (speed_expect_q.size() != 0);
    endtask

    // Drain, then let any poll still in flight finish before touching registers.
    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_PULSES_PER_REV)
            meter_ppr = val;
        else if (idx == REG_FILTER_ALPHA)
            meter_alpha = val;
    endtask

    // No history, unchanged count, zero, huge, negative and unit periods, divide limits.
    task automatic test_history_cases();
        send_request();
        send_item(ACT_POLL, 32'd0, 63'd500);
        send_item(ACT_POLL, 32'h8000_0000, 63'd1000);
        send_request();
        send_item(ACT_POLL, 32'h7FFF_FFFF, 63'd1000);
        send_request();
        send_item(ACT_POLL, 32'd1, 63'd51000);
        drain_results();
        send_request();
        send_request();
        send_item(ACT_POLL, 32'd2, TS_MAX);
        send_request();
        send_item(ACT_POLL, 32'd3, 63'd0);
        send_request();
        send_item(ACT_POLL, 32'd4, 63'd1);
        send_request();
        send_item(ACT_POLL, 32'd5, 63'd1 + MINUTE_Q[62:0]);
        send_request();
        send_item(ACT_POLL, 32'd6, 63'd2 + 63'd2 * MINUTE_Q[62:0]);
        send_request();
    endtask

    // Zero and full-scale register values, plus a write to an unused index.
    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_PULSES_PER_REV, 16'd0);
        write_reg(REG_FILTER_ALPHA, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_item(ACT_POLL, 32'd7, 63'd1002 + 63'd2 * MINUTE_Q[62:0]);
        send_request();
        wait_idle();
        write_reg(REG_PULSES_PER_REV, 16'd1);
        write_reg(REG_FILTER_ALPHA, 16'd0);
        send_request();
        wait_idle();
        write_reg(REG_PULSES_PER_REV, 16'hFFFF);
        send_request();
    endtask

    // One phase of random traffic under its own registers and idling profile.
    task automatic test_random_traffic(input int phase);
        int          pick;
        logic [62:0] gap;
        logic [63:0] wide;
        wait_idle();
        case (phase)
            0:
            begin
                write_reg(REG_PULSES_PER_REV, PPR_RESET);
                write_reg(REG_FILTER_ALPHA, ALPHA_RESET);
            end
            1:
            begin
                write_reg(REG_PULSES_PER_REV, 16'd1);
                write_reg(REG_FILTER_ALPHA, 16'hFFFF);
            end
            4:
            begin
                write_reg(REG_PULSES_PER_REV, 16'hFFFF);
                write_reg(REG_FILTER_ALPHA, 16'd1);
            end
            default:
            begin
                write_reg(REG_PULSES_PER_REV, CFG_W'($urandom_range(1, 64)));
                write_reg(REG_FILTER_ALPHA, CFG_W'($urandom_range(0, 65535)));
            end
        endcase
        case (phase % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 68; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
        endcase
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                drain_results();
            if (pick < 45)
            begin
                // Count moves on after a mostly realistic gap, sometimes at the divide limits.
                case ($urandom_range(9))
                    6:       gap = 63'($urandom_range(1, 16));
                    7:       gap = '0;
                    8:       gap = {29'd0, 2'($urandom_range(3)), 32'($urandom)};
                    9:       gap = MINUTE_Q[62:0] - 63'd8 + 63'($urandom_range(16));
                    default: gap = 63'($urandom_range(1, 200000));
                endcase
                if ($urandom_range(1))
                    gen_count = gen_count + 32'($urandom_range(1, 8));
                else
                    gen_count = gen_count - 32'($urandom_range(1, 8));
                gen_time_us = gen_time_us + gap;
                send_item(ACT_POLL, gen_count, gen_time_us);
            end
            else if (pick < 55)
            begin
                gen_time_us = gen_time_us + 63'($urandom_range(0, 1000));
                send_item(ACT_POLL, gen_count, gen_time_us);
            end
            else if (pick < 85)
                send_request();
            else if (pick < 93)
            begin
                // Noise: arbitrary count and time, which then become the new baseline.
                wide        = {$urandom, $urandom};
                gen_time_us = wide[62:0];
                gen_count   = $urandom;
                send_item(ACT_POLL, gen_count, gen_time_us);
            end
            else
            begin
                // Broken sequence: time steps backwards across a count change.
                gen_time_us = gen_time_us - 63'($urandom_range(1, 100000));
                gen_count   = gen_count + 32'd1;
                send_item(ACT_POLL, gen_count, gen_time_us);
            end
        end
    endtask

    // Random back-pressure on the result channel.
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each result transfer with the oldest expected speed.
    always @(posedge clk)
    begin : result_check
        speed_result_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (speed_expect_q.size() == 0)
            begin
                $error("unexpected result: rpm_q8 %0d has_period %0d",
                       result_ch.rpm_q8, result_ch.has_period);
                err_count++;
            end
            else
            begin
                want = speed_expect_q.pop_front();
                if (result_ch.rpm_q8 !== want.rpm_q8)
                begin
                    $error("rpm_q8 mismatch: expected %0d, actual %0d",
                           want.rpm_q8, result_ch.rpm_q8);
                    err_count++;
                end
                if (result_ch.has_period !== want.has_period)
                begin
                    $error("has_period mismatch: expected %0d, actual %0d",
                           want.has_period, result_ch.has_period);
                    err_count++;
                end
            end
        end
    end

    // Stop a hung run: too many cycles without any transfer on any channel.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pulse_period_rpm_meter regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.action       = ACT_POLL;
        item_ch.pulse_count  = '0;
        item_ch.timestamp_us = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_PULSES_PER_REV;
        cfg_ch.data          = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_history_cases();
        test_register_extremes();
        for (int p = 0; p < RANDOM_PHASES; p++)
            test_random_traffic(p);
        wait_idle();

        if (err_count == 0 && speed_expect_q.size() == 0)
            $display("pulse_period_rpm_meter regression: pass");
        else
            $display("pulse_period_rpm_meter regression: fail");
        $finish;
    end

endmodule
